/* hdl/fjkv_pkg.sv */
// ---------------------------------------------------------------------------
// fjkv_pkg
// Shared character codes, helper function and controller/datapath bundles
// for the flat JSON key/value splitter.
// ---------------------------------------------------------------------------
package fjkv_pkg;

    localparam int BYTE_W      = 8;
    localparam int SPACE_CNT_W = 6;
    localparam int NULL_LEN    = 4;

    localparam logic [SPACE_CNT_W-1:0] SPACE_CNT_MAX = 6'd63;

    // character codes
    localparam logic [BYTE_W-1:0] CHR_SPACE  = 8'h20;
    localparam logic [BYTE_W-1:0] CHR_LBRACE = 8'h7B;
    localparam logic [BYTE_W-1:0] CHR_RBRACE = 8'h7D;
    localparam logic [BYTE_W-1:0] CHR_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CHR_QUOTE  = 8'h22;
    localparam logic [BYTE_W-1:0] CHR_COMMA  = 8'h2C;
    localparam logic [BYTE_W-1:0] CHR_COLON  = 8'h3A;
    localparam logic [BYTE_W-1:0] CHR_N      = 8'h6E;
    localparam logic [BYTE_W-1:0] CHR_U      = 8'h75;
    localparam logic [BYTE_W-1:0] CHR_L      = 8'h6C;

    // expected character of the literal null at a given position
    function automatic logic [BYTE_W-1:0] null_char(input logic [1:0] pos);
        logic [BYTE_W-1:0] ch;
        unique case (pos)
            2'd0:    ch = CHR_N;
            2'd1:    ch = CHR_U;
            default: ch = CHR_L;
        endcase
        return ch;
    endfunction

    // commands from the controller
    typedef struct packed {
        logic accept;
        logic char_en;
        logic char_src_hold;
        logic brace_en;
        logic space_en;
        logic prep_en;
        logic prep_final;
        logic send_en;
        logic clear_token;
        logic reset_all;
    } fjkv_cmd_t;

    // status back to the controller
    typedef struct packed {
        logic in_direct;
        logic in_defer;
        logic in_end;
        logic hold_end;
        logic sep;
        logic brace_pending;
        logic spaces_pending;
        logic spaces_one;
        logic send_done;
    } fjkv_status_t;

endpackage

/* hdl/fjkv_ctrl.sv */
// ---------------------------------------------------------------------------
// fjkv_ctrl
// Sequencer for the splitter: takes input transfers, steps through a held
// closing brace and held spaces, and runs token replay.
// ---------------------------------------------------------------------------
module fjkv_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  fjkv_pkg::fjkv_status_t st,
    output fjkv_pkg::fjkv_cmd_t    cmd
);
    import fjkv_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_BRACE  = 6'b000010,
        ST_SPACES = 6'b000100,
        ST_CHAR   = 6'b001000,
        ST_PREP   = 6'b010000,
        ST_SEND   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   final_reg, final_next;

    // next state and command decode
    always_comb begin
        state_next = state_reg;
        final_next = final_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    if (st.in_direct) begin
                        cmd.char_en = 1'b1;
                        if (st.sep) begin
                            state_next = ST_PREP;
                            final_next = 1'b0;
                        end else if (st.in_end) begin
                            state_next = ST_PREP;
                            final_next = 1'b1;
                        end
                    end else if (st.in_defer) begin
                        state_next = st.brace_pending ? ST_BRACE : ST_SPACES;
                    end else if (st.in_end) begin
                        state_next = ST_PREP;
                        final_next = 1'b1;
                    end
                end
            end
            ST_BRACE: begin
                cmd.brace_en = 1'b1;
                state_next   = st.spaces_pending ? ST_SPACES : ST_CHAR;
            end
            ST_SPACES: begin
                cmd.space_en = 1'b1;
                if (st.spaces_one) begin
                    state_next = ST_CHAR;
                end
            end
            ST_CHAR: begin
                cmd.char_en       = 1'b1;
                cmd.char_src_hold = 1'b1;
                if (st.sep) begin
                    state_next = ST_PREP;
                    final_next = 1'b0;
                end else if (st.hold_end) begin
                    state_next = ST_PREP;
                    final_next = 1'b1;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_PREP: begin
                cmd.prep_en    = 1'b1;
                cmd.prep_final = final_reg;
                state_next     = ST_SEND;
            end
            ST_SEND: begin
                cmd.send_en = 1'b1;
                if (st.send_done) begin
                    if (final_reg) begin
                        cmd.reset_all = 1'b1;
                        state_next    = ST_IDLE;
                    end else begin
                        cmd.clear_token = 1'b1;
                        if (st.hold_end) begin
                            state_next = ST_PREP;
                            final_next = 1'b1;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            final_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            final_reg <= final_next;
        end
    end

endmodule

/* hdl/fjkv_datapath.sv */
// ---------------------------------------------------------------------------
// fjkv_datapath
// Parse state, token store, replay index and result register of the
// splitter, driven by the controller's commands.
// ---------------------------------------------------------------------------
module fjkv_datapath #(
    parameter int MAX_TOKEN = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [7:0]             s_in_byte,
    input  logic                   s_end_of_text,
    input  fjkv_pkg::fjkv_cmd_t    cmd,
    output fjkv_pkg::fjkv_status_t st,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [7:0]             m_token_byte,
    output logic                   m_is_key,
    output logic                   m_is_null,
    output logic                   m_is_empty,
    output logic                   m_truncated,
    output logic                   m_token_last,
    output logic                   m_record_end
);
    import fjkv_pkg::*;

    localparam int LEN_W  = $clog2(MAX_TOKEN + 1);
    localparam int ADDR_W = $clog2(MAX_TOKEN);

    // parse state
    logic                   quotes_reg;
    logic                   parity_reg;
    logic                   expect_key_reg;
    logic                   seen_reg;
    logic                   brace_reg;
    logic [SPACE_CNT_W-1:0] space_cnt_reg;
    logic [LEN_W-1:0]       len_reg;
    logic                   overflow_reg;
    logic                   first_quote_reg;
    logic                   last_quote_reg;
    logic                   null_ok_reg;

    // held input transfer
    logic [BYTE_W-1:0]      hold_byte_reg;
    logic                   hold_end_reg;

    // replay descriptor
    logic                   em_key_reg;
    logic                   em_null_reg;
    logic                   em_empty_reg;
    logic                   em_trunc_reg;
    logic                   em_final_reg;
    logic                   em_single_reg;
    logic [LEN_W-1:0]       em_end_reg;
    logic [LEN_W-1:0]       idx_reg, idx_next;

    // token store
    logic [BYTE_W-1:0]      mem [MAX_TOKEN];
    logic [BYTE_W-1:0]      rd_data_reg;
    logic [ADDR_W-1:0]      rd_addr;

    // result register
    logic                   m_valid_reg;
    logic [BYTE_W-1:0]      out_byte_reg;
    logic                   out_key_reg;
    logic                   out_null_reg;
    logic                   out_empty_reg;
    logic                   out_trunc_reg;
    logic                   out_last_reg;
    logic                   out_rec_reg;

    logic [BYTE_W-1:0]      cur_byte;
    logic                   cur_sep;
    logic                   in_space;
    logic                   in_consumed;
    logic [BYTE_W-1:0]      feed_byte;
    logic                   feed_en;
    logic                   f_skip;
    logic                   f_bslash;
    logic                   f_quote;
    logic                   f_sep;
    logic                   append_en;
    logic                   has_room;
    logic                   tok_null;
    logic                   strip;
    logic [LEN_W-1:0]       s_calc;
    logic [LEN_W-1:0]       e_calc;
    logic                   pre_null;
    logic                   pre_cut;
    logic                   out_free;
    logic                   out_load;
    logic                   out_last;

    // classification of the byte on the input port and of the byte in work
    always_comb begin
        in_space    = (s_in_byte == CHR_SPACE);
        in_consumed = !seen_reg && (in_space || (s_in_byte == CHR_LBRACE));
        cur_byte    = cmd.char_src_hold ? hold_byte_reg : s_in_byte;
        cur_sep     = ((cur_byte == CHR_COMMA) || (cur_byte == CHR_COLON)) && !quotes_reg;
    end

    // byte fed to the tokeniser: held brace, held space or the byte in work
    always_comb begin
        if (cmd.brace_en) begin
            feed_byte = CHR_RBRACE;
        end else if (cmd.space_en) begin
            feed_byte = CHR_SPACE;
        end else begin
            feed_byte = cur_byte;
        end
        feed_en   = cmd.brace_en || cmd.space_en ||
                    (cmd.char_en && (cur_byte != CHR_RBRACE));
        f_skip    = (feed_byte == CHR_SPACE) && !quotes_reg;
        f_bslash  = (feed_byte == CHR_BSLASH);
        f_quote   = (feed_byte == CHR_QUOTE) && !parity_reg;
        f_sep     = ((feed_byte == CHR_COMMA) || (feed_byte == CHR_COLON)) && !quotes_reg;
        append_en = feed_en && !f_skip && !f_sep;
        has_room  = (len_reg < LEN_W'(MAX_TOKEN));
    end

    // replay set-up from the finished token
    always_comb begin
        tok_null = null_ok_reg && (len_reg == LEN_W'(NULL_LEN)) && !overflow_reg;
        strip    = (len_reg != '0) && first_quote_reg && last_quote_reg &&
                   ((len_reg > LEN_W'(1)) || overflow_reg);
        s_calc   = strip ? LEN_W'(1) : '0;
        e_calc   = (strip && !overflow_reg) ? (len_reg - LEN_W'(1)) : len_reg;
        pre_null = tok_null || (cmd.prep_final && (len_reg == '0));
        pre_cut  = (e_calc <= s_calc);
    end

    // replay stepping and store read address
    always_comb begin
        out_free = !m_valid_reg || m_ready;
        out_load = cmd.send_en && out_free;
        out_last = em_single_reg || ((idx_reg + LEN_W'(1)) == em_end_reg);
        if (cmd.prep_en) begin
            idx_next = s_calc;
        end else if (out_load && !em_single_reg) begin
            idx_next = idx_reg + LEN_W'(1);
        end else begin
            idx_next = idx_reg;
        end
        rd_addr = idx_next[ADDR_W-1:0];
    end

    // status to the controller
    always_comb begin
        st.in_direct      = !in_consumed && !in_space && !brace_reg && (space_cnt_reg == '0);
        st.in_defer       = !in_consumed && !in_space && (brace_reg || (space_cnt_reg != '0));
        st.in_end         = s_end_of_text;
        st.hold_end       = hold_end_reg;
        st.sep            = cur_sep;
        st.brace_pending  = brace_reg;
        st.spaces_pending = (space_cnt_reg != '0);
        st.spaces_one     = (space_cnt_reg == SPACE_CNT_W'(1));
        st.send_done      = out_load && out_last;
    end

    // parse state registers
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.reset_all) begin
            quotes_reg      <= 1'b0;
            parity_reg      <= 1'b0;
            expect_key_reg  <= 1'b1;
            seen_reg        <= 1'b0;
            brace_reg       <= 1'b0;
            space_cnt_reg   <= '0;
            len_reg         <= '0;
            overflow_reg    <= 1'b0;
            first_quote_reg <= 1'b0;
            last_quote_reg  <= 1'b0;
            null_ok_reg     <= 1'b1;
        end else begin
            // first significant character and held spaces
            if (cmd.accept && !seen_reg && !in_space) begin
                seen_reg <= 1'b1;
            end
            if (cmd.accept && !in_consumed && in_space && quotes_reg &&
                (space_cnt_reg < SPACE_CNT_MAX)) begin
                space_cnt_reg <= space_cnt_reg + SPACE_CNT_W'(1);
            end
            if (cmd.space_en) begin
                space_cnt_reg <= space_cnt_reg - SPACE_CNT_W'(1);
            end
            // closing brace held until it is known not to be last
            if (cmd.char_en && (cur_byte == CHR_RBRACE)) begin
                brace_reg <= 1'b1;
            end
            if (cmd.brace_en) begin
                brace_reg <= 1'b0;
            end
            // quote and backslash tracking
            if (feed_en && !f_skip) begin
                if (f_bslash) begin
                    parity_reg <= !parity_reg;
                end else if (f_quote) begin
                    quotes_reg <= !quotes_reg;
                    parity_reg <= 1'b0;
                end else if (!f_sep) begin
                    parity_reg <= 1'b0;
                end
            end
            // token append
            if (append_en) begin
                last_quote_reg <= (feed_byte == CHR_QUOTE);
                if (has_room) begin
                    len_reg <= len_reg + LEN_W'(1);
                    if (len_reg == '0) begin
                        first_quote_reg <= (feed_byte == CHR_QUOTE);
                    end
                    if (len_reg < LEN_W'(NULL_LEN)) begin
                        null_ok_reg <= null_ok_reg &&
                                       (feed_byte == null_char(len_reg[1:0]));
                    end
                end else begin
                    overflow_reg <= 1'b1;
                end
            end
            // start of the next token after a separator
            if (cmd.clear_token) begin
                len_reg        <= '0;
                overflow_reg   <= 1'b0;
                last_quote_reg <= 1'b0;
                parity_reg     <= 1'b0;
                null_ok_reg    <= 1'b1;
                expect_key_reg <= !expect_key_reg;
            end
        end
    end

    // held input transfer
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            hold_byte_reg <= s_in_byte;
            hold_end_reg  <= s_end_of_text;
        end
    end

    // token store, registered read
    always_ff @(posedge aclk) begin
        if (append_en && has_room) begin
            mem[len_reg[ADDR_W-1:0]] <= feed_byte;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // replay descriptor and index
    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        if (cmd.prep_en) begin
            em_key_reg    <= cmd.prep_final ? 1'b0 : expect_key_reg;
            em_final_reg  <= cmd.prep_final;
            em_single_reg <= pre_null || pre_cut;
            em_null_reg   <= pre_null;
            em_empty_reg  <= pre_null ? (len_reg == '0) : 1'b1;
            em_trunc_reg  <= pre_null ? 1'b0 : overflow_reg;
            em_end_reg    <= e_calc;
        end
    end

    // result register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_byte_reg  <= em_single_reg ? '0 : rd_data_reg;
            out_key_reg   <= em_key_reg;
            out_null_reg  <= em_single_reg && em_null_reg;
            out_empty_reg <= em_single_reg && em_empty_reg;
            out_trunc_reg <= em_trunc_reg;
            out_last_reg  <= out_last;
            out_rec_reg   <= em_final_reg && out_last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_token_byte = out_byte_reg;
    assign m_is_key     = out_key_reg;
    assign m_is_null    = out_null_reg;
    assign m_is_empty   = out_empty_reg;
    assign m_truncated  = out_trunc_reg;
    assign m_token_last = out_last_reg;
    assign m_record_end = out_rec_reg;

endmodule

/* hdl/flat_json_key_value_splitter_top.sv */
// ---------------------------------------------------------------------------
// flat_json_key_value_splitter_top
// Splits the text of one flat JSON object into key and value tokens and
// replays each finished token one byte per result transfer.
// ---------------------------------------------------------------------------
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  s_      | s_valid s_ready s_in_byte s_end_of_text | in
//  m_      | m_valid m_ready m_token_byte m_is_key   | out
//          | m_is_null m_is_empty m_truncated        |
//          | m_token_last m_record_end               |
//
//  an ordinary byte is taken and fed directly; a byte after a held closing brace or held
//  spaces is taken, then the brace, each held space and the byte itself are fed in turn
//  a separator or end of text adds a set-up step and then one result per
//  cycle while the output register is free, as set by the single read port
//  of the token store; reset clears the parse state, sequencer state and
//  result valid flag; the token store needs no clearing
//  while a result waits in the output register replay stalls, and input
//  transfers are taken again once the replay is done
//
module flat_json_key_value_splitter_top #(
    parameter int MAX_TOKEN = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_end_of_text,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_token_byte,
    output logic       m_is_key,
    output logic       m_is_null,
    output logic       m_is_empty,
    output logic       m_truncated,
    output logic       m_token_last,
    output logic       m_record_end
);
    import fjkv_pkg::*;

    fjkv_cmd_t    cmd;
    fjkv_status_t st;

    // sequencer
    fjkv_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    // parse state, token store and result register
    fjkv_datapath #(
        .MAX_TOKEN (MAX_TOKEN)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_in_byte     (s_in_byte),
        .s_end_of_text (s_end_of_text),
        .cmd           (cmd),
        .st            (st),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_token_byte  (m_token_byte),
        .m_is_key      (m_is_key),
        .m_is_null     (m_is_null),
        .m_is_empty    (m_is_empty),
        .m_truncated   (m_truncated),
        .m_token_last  (m_token_last),
        .m_record_end  (m_record_end)
    );

endmodule

/* bench/fjkv_token_checker.sv */
// ---------------------------------------------------------------------------
// fjkv_token_checker
// Watches both channels of the splitter, runs its own parser on every input
// transfer to build the token bytes it should replay, and compares each result
// transfer field by field with the oldest outstanding one.
// ---------------------------------------------------------------------------
module fjkv_token_checker #(
    parameter int MAX_TOKEN = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_end_of_text,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_token_byte,
    input  logic       m_is_key,
    input  logic       m_is_null,
    input  logic       m_is_empty,
    input  logic       m_truncated,
    input  logic       m_token_last,
    input  logic       m_record_end,
    output int         mismatch_count,
    output int         pending_count
);

    import fjkv_pkg::*;

    // one replayed token byte with its flags
    typedef struct packed {
        logic [7:0] tbyte;
        logic       key;
        logic       nul;
        logic       empty;
        logic       cut;
        logic       last;
        logic       rec;
    } token_beat_t;

    token_beat_t expected_tokens[$];

    // parser state
    logic                   in_str;
    logic                   esc_odd;
    logic                   want_key;
    logic                   started;
    logic                   brace_held;
    logic [SPACE_CNT_W-1:0] held_spaces;
    logic [7:0]             tok_buf [MAX_TOKEN];
    int                     tok_len;
    logic                   tok_cut;
    logic [7:0]             tok_tail;

    int err_total  = 0;
    int waiting    = 0;
    int beats_seen = 0;

    assign mismatch_count = err_total;
    assign pending_count  = waiting;

    task automatic report_mismatch(input string msg);
        if (err_total < 100)
            $display("mismatch on result %0d: %s", beats_seen, msg);
        err_total++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    task automatic clear_parser();
        in_str      = 1'b0;
        esc_odd     = 1'b0;
        want_key    = 1'b1;
        started     = 1'b0;
        brace_held  = 1'b0;
        held_spaces = '0;
        tok_len     = 0;
        tok_cut     = 1'b0;
        tok_tail    = 8'h00;
    endtask

    task automatic add_beat(input logic [7:0] b, input logic k, input logic n,
                            input logic e, input logic c, input logic l,
                            input logic r);
        token_beat_t beat;
        beat = '{tbyte: b, key: k, nul: n, empty: e, cut: c, last: l, rec: r};
        expected_tokens.insert(expected_tokens.size(), beat);
    endtask

    // store a token byte, dropping it once the buffer is full
    task automatic store_byte(input logic [7:0] c);
        if (tok_len < MAX_TOKEN) begin
            tok_buf[tok_len] = c;
            tok_len++;
        end else begin
            tok_cut = 1'b1;
        end
        tok_tail = c;
    endtask

    function automatic logic token_is_null_word();
        return !tok_cut && tok_len == NULL_LEN &&
               tok_buf[0] == CHR_N && tok_buf[1] == CHR_U &&
               tok_buf[2] == CHR_L && tok_buf[3] == CHR_L;
    endfunction

    // replay the buffered token as result beats
    task automatic replay_token(input logic at_end);
        logic key;
        int   first;
        int   stop;
        key   = at_end ? 1'b0 : want_key;
        first = 0;
        stop  = tok_len;
        if (token_is_null_word() || (at_end && tok_len == 0)) begin
            add_beat(8'h00, key, 1'b1, tok_len == 0, 1'b0, 1'b1, at_end);
            return;
        end
        // strip enclosing quotes; a cut token lost its closing quote already
        if (tok_len > 0 && tok_buf[0] == CHR_QUOTE && tok_tail == CHR_QUOTE &&
            (tok_len > 1 || tok_cut)) begin
            first = 1;
            if (!tok_cut)
                stop = tok_len - 1;
        end
        if (stop <= first) begin
            add_beat(8'h00, key, 1'b0, 1'b1, tok_cut, 1'b1, at_end);
            return;
        end
        for (int i = first; i < stop; i++)
            add_beat(tok_buf[i], key, 1'b0, 1'b0, tok_cut, i + 1 == stop,
                     at_end && i + 1 == stop);
    endtask

    // one character into the tokeniser proper
    task automatic parse_char(input logic [7:0] c);
        if (c == CHR_SPACE && !in_str)
            return;
        if (c == CHR_BSLASH) begin
            esc_odd = ~esc_odd;
            store_byte(c);
        end else if (c == CHR_QUOTE && !esc_odd) begin
            in_str = ~in_str;
            store_byte(c);
            esc_odd = 1'b0;
        end else if ((c == CHR_COMMA || c == CHR_COLON) && !in_str) begin
            replay_token(1'b0);
            want_key = ~want_key;
            tok_len  = 0;
            tok_cut  = 1'b0;
            tok_tail = 8'h00;
            esc_odd  = 1'b0;
        end else begin
            store_byte(c);
            esc_odd = 1'b0;
        end
    endtask

    // one input transfer: leading brace, held closing brace and spaces
    task automatic take_char(input logic [7:0] c, input logic at_end);
        logic consumed;
        consumed = 1'b0;
        if (!started) begin
            if (c == CHR_SPACE) begin
                consumed = 1'b1;
            end else begin
                started = 1'b1;
                if (c == CHR_LBRACE)
                    consumed = 1'b1;
            end
        end
        if (!consumed) begin
            if (c == CHR_SPACE) begin
                if (in_str && held_spaces < SPACE_CNT_MAX)
                    held_spaces++;
            end else begin
                if (brace_held) begin
                    brace_held = 1'b0;
                    parse_char(CHR_RBRACE);
                end
                while (held_spaces != 0) begin
                    held_spaces--;
                    parse_char(CHR_SPACE);
                end
                if (c == CHR_RBRACE)
                    brace_held = 1'b1;
                else
                    parse_char(c);
            end
        end
        if (at_end) begin
            replay_token(1'b1);
            clear_parser();
        end
    endtask

    // predict on input transfers, compare on result transfers
    always @(posedge aclk) begin
        token_beat_t got;
        token_beat_t want;
        if (!aresetn) begin
            clear_parser();
            expected_tokens.delete();
        end else begin
            if (s_valid && s_ready)
                take_char(s_in_byte, s_end_of_text);
            if (m_valid && m_ready) begin
                got = '{tbyte: m_token_byte, key: m_is_key, nul: m_is_null,
                        empty: m_is_empty, cut: m_truncated, last: m_token_last,
                        rec: m_record_end};
                if (expected_tokens.size() == 0) begin
                    report_mismatch($sformatf("unexpected result, byte %0h", got.tbyte));
                end else begin
                    want = expected_tokens.pop_front();
                    check_field("token_byte", got.tbyte, want.tbyte);
                    check_field("is_key", got.key, want.key);
                    check_field("is_null", got.nul, want.nul);
                    check_field("is_empty", got.empty, want.empty);
                    check_field("truncated", got.cut, want.cut);
                    check_field("token_last", got.last, want.last);
                    check_field("record_end", got.rec, want.rec);
                end
                beats_seen++;
            end
        end
        waiting <= expected_tokens.size();
    end

endmodule

/* bench/tb_flat_json_key_value_splitter_top.sv */
// ---------------------------------------------------------------------------
// tb_flat_json_key_value_splitter_top
// Feeds the splitter with directed texts and then random objects, broken
// objects and byte noise under several idling patterns; a separate checker
// predicts and compares the token stream and this module gives the verdict.
// ---------------------------------------------------------------------------
module tb_flat_json_key_value_splitter_top;

    import fjkv_pkg::*;

    localparam int MAX_TOK      = 32;
    localparam int RANDOM_ITEMS = 190;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int TAIL_CYCLES  = 40;

    logic       aclk          = 1'b0;
    logic       aresetn       = 1'b0;
    logic       s_valid       = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte     = 8'h00;
    logic       s_end_of_text = 1'b0;
    logic       m_valid;
    logic       m_ready       = 1'b0;
    logic [7:0] m_token_byte;
    logic       m_is_key;
    logic       m_is_null;
    logic       m_is_empty;
    logic       m_truncated;
    logic       m_token_last;
    logic       m_record_end;

    int mismatch_count;
    int pending_count;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    logic [7:0] obj_bytes[$];

    always #5 aclk = ~aclk;

    flat_json_key_value_splitter_top #(
        .MAX_TOKEN(MAX_TOK)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_in_byte    (s_in_byte),
        .s_end_of_text(s_end_of_text),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_token_byte (m_token_byte),
        .m_is_key     (m_is_key),
        .m_is_null    (m_is_null),
        .m_is_empty   (m_is_empty),
        .m_truncated  (m_truncated),
        .m_token_last (m_token_last),
        .m_record_end (m_record_end)
    );

    fjkv_token_checker #(
        .MAX_TOKEN(MAX_TOK)
    ) u_token_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .s_end_of_text (s_end_of_text),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_token_byte  (m_token_byte),
        .m_is_key      (m_is_key),
        .m_is_null     (m_is_null),
        .m_is_empty    (m_is_empty),
        .m_truncated   (m_truncated),
        .m_token_last  (m_token_last),
        .m_record_end  (m_record_end),
        .mismatch_count(mismatch_count),
        .pending_count (pending_count)
    );

    // receiver back-pressure
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // run watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // letters and digits
    function automatic logic [7:0] plain_char();
        logic [7:0] ch;
        case ($urandom_range(2))
            0:       ch = 8'h61 + 8'($urandom_range(25));
            1:       ch = 8'h41 + 8'($urandom_range(25));
            default: ch = 8'h30 + 8'($urandom_range(9));
        endcase
        return ch;
    endfunction

    // characters the parser treats specially, or any byte at all
    function automatic logic [7:0] odd_char();
        logic [7:0] ch;
        case ($urandom_range(7))
            0:       ch = CHR_SPACE;
            1:       ch = CHR_COMMA;
            2:       ch = CHR_COLON;
            3:       ch = CHR_BSLASH;
            4:       ch = CHR_QUOTE;
            5:       ch = CHR_LBRACE;
            6:       ch = CHR_RBRACE;
            default: ch = 8'($urandom_range(255));
        endcase
        return ch;
    endfunction

    // append one byte to the text being built
    task automatic put_byte(input logic [7:0] b);
        obj_bytes.insert(obj_bytes.size(), b);
    endtask

    task automatic push_text(input string t);
        for (int i = 0; i < t.len(); i++)
            put_byte(t[i]);
    endtask

    task automatic add_spaces(input int most);
        repeat ($urandom_range(most)) put_byte(CHR_SPACE);
    endtask

    // quoted string with escapes, separators and stray bytes inside
    task automatic add_quoted(input int len);
        int r;
        put_byte(CHR_QUOTE);
        repeat (len) begin
            r = $urandom_range(99);
            if (r < 70) begin
                put_byte(plain_char());
            end else if (r < 80) begin
                put_byte(CHR_SPACE);
            end else if (r < 85) begin
                put_byte(CHR_COMMA);
            end else if (r < 88) begin
                put_byte(CHR_COLON);
            end else if (r < 94) begin
                put_byte(CHR_BSLASH);
                put_byte($urandom_range(1) ? CHR_QUOTE : plain_char());
            end else begin
                put_byte(8'($urandom_range(255)));
            end
        end
        put_byte(CHR_QUOTE);
    endtask

    task automatic add_bare(input int len);
        repeat (len) begin
            if ($urandom_range(9) == 0)
                put_byte($urandom_range(1) ? CHR_RBRACE : CHR_LBRACE);
            else
                put_byte(plain_char());
        end
    endtask

    task automatic add_token();
        int r;
        r = $urandom_range(99);
        if (r < 42) begin
            add_quoted($urandom_range(8));
        end else if (r < 58) begin
            add_bare($urandom_range(1, 6));
        end else if (r < 68) begin
            push_text("null");
        end else if (r < 75) begin
            // empty token
        end else if (r < 83) begin
            add_quoted($urandom_range(28, 40));
        end else if (r < 87) begin
            add_bare($urandom_range(30, 40));
        end else if (r < 92) begin
            push_text("\"null\"");
        end else begin
            add_quoted($urandom_range(1, 2));
        end
    endtask

    // object with random pairs and spacing, its braces occasionally left out
    task automatic build_object();
        int pairs;
        obj_bytes.delete();
        add_spaces(2);
        if ($urandom_range(9) != 0)
            put_byte(CHR_LBRACE);
        add_spaces(1);
        pairs = $urandom_range(4);
        for (int p = 0; p < pairs; p++) begin
            if (p > 0)
                put_byte(CHR_COMMA);
            add_spaces(1);
            add_token();
            add_spaces(1);
            put_byte(CHR_COLON);
            add_spaces(1);
            add_token();
            add_spaces(1);
        end
        if ($urandom_range(9) != 0)
            put_byte(CHR_RBRACE);
        add_spaces(2);
        if (obj_bytes.size() == 0)
            put_byte(CHR_SPACE);
    endtask

    task automatic build_noise();
        obj_bytes.delete();
        repeat ($urandom_range(1, 12)) begin
            if ($urandom_range(1))
                put_byte(8'($urandom_range(255)));
            else
                put_byte(odd_char());
        end
    endtask

    // key holding more spaces than the space counter can keep
    task automatic build_space_run();
        obj_bytes.delete();
        put_byte(CHR_LBRACE);
        put_byte(CHR_QUOTE);
        repeat (66) put_byte(CHR_SPACE);
        put_byte(CHR_QUOTE);
        put_byte(CHR_COLON);
        add_bare(3);
        put_byte(CHR_RBRACE);
    endtask

    // one input transfer, with random idle cycles before it
    task automatic send_byte(input logic [7:0] b, input logic last);
        @(negedge aclk);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do begin
                @(negedge aclk);
            end while ($urandom_range(99) < send_idle_pct);
        end
        s_valid       <= 1'b1;
        s_in_byte     <= b;
        s_end_of_text <= last;
        do begin
            @(posedge aclk);
        end while (!s_ready);
    endtask

    task automatic send_seq();
        for (int i = 0; i < obj_bytes.size(); i++)
            send_byte(obj_bytes[i], i == obj_bytes.size() - 1);
    endtask

    task automatic send_text(input string t);
        obj_bytes.delete();
        push_text(t);
        send_seq();
    endtask

    // hold off the sender until every expected result has come out
    task automatic wait_drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge aclk);
    endtask

    task automatic set_idle(input int phase);
        case (phase)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 86; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 86; end
            default: begin send_idle_pct = 19; recv_stall_pct = 19; end
        endcase
        // occasional stretch with no idling at all
        if (phase != 0 && $urandom_range(5) == 0) begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
        end
    endtask

    // stimulus and verdict
    initial begin
        int   rand_bytes;
        int   phase;
        int   next_phase;
        int   r;
        int   keep;
        logic space_run_done;
        rand_bytes     = 0;
        phase          = 0;
        space_run_done = 1'b0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty objects, null value, empty tokens, byte extremes,
        // a closing brace that is not the last character
        set_idle(0);
        send_text("{}");
        send_text(" ");
        send_text("{\"k\":null}");
        send_text(":,");
        obj_bytes.delete();
        put_byte(CHR_LBRACE);
        put_byte(8'h00);
        put_byte(CHR_COLON);
        put_byte(8'hFF);
        put_byte(CHR_RBRACE);
        send_seq();
        send_text("a}b");
        wait_drain();

        // random objects, broken objects and noise over the idling phases
        while (rand_bytes < RANDOM_ITEMS) begin
            next_phase = rand_bytes * 4 / RANDOM_ITEMS;
            if (next_phase != phase) begin
                wait_drain();
                phase = next_phase;
            end
            set_idle(phase);
            if (phase >= 2 && !space_run_done) begin
                build_space_run();
                space_run_done = 1'b1;
            end else begin
                r = $urandom_range(99);
                if (r < 80) begin
                    build_object();
                end else if (r < 88) begin
                    build_object();
                    if (obj_bytes.size() > 1) begin
                        keep = $urandom_range(1, obj_bytes.size() - 1);
                        while (obj_bytes.size() > keep)
                            void'(obj_bytes.pop_back());
                    end
                end else begin
                    build_noise();
                end
            end
            rand_bytes += obj_bytes.size();
            send_seq();
        end

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
